### rtl/core/kti_pkg.sv
`default_nettype none

package kti_pkg;

    // Operation codes carried by an input transaction
    typedef enum logic [2:0] {
        OP_ADD_KEY  = 3'd0,
        OP_ADVANCE  = 3'd1,
        OP_PLAY     = 3'd2,
        OP_PAUSE    = 3'd3,
        OP_STOP     = 3'd4,
        OP_SET_DUR  = 3'd5
    } t_op;

    // Loop modes; the fourth code behaves as play once
    localparam logic [1:0] MODE_ONCE     = 2'd0;
    localparam logic [1:0] MODE_WRAP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_LOOP_MODE = 1'b0;
    localparam logic REG_SPEED     = 1'b1;

    localparam logic [15:0] SPEED_RESET = 16'd256;

    localparam int KEY_W      = 128;
    localparam int MOD_STEPS  = 34;
    localparam int FRAC_STEPS = 16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WT,
        S_INS_PUT,
        S_ADV_ADD,
        S_MOD_DIV,
        S_MOD_DONE,
        S_EV_START,
        S_EV_K0,
        S_EV_KL,
        S_EV_SCAN,
        S_FRAC,
        S_FRAC_DIV,
        S_FRAC_TAKE,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_CTRL,
        CMD_DROP,
        CMD_INS_READ,
        CMD_INS_SHIFT,
        CMD_INS_PUT,
        CMD_ADV_MUL,
        CMD_ADV_ADD,
        CMD_DIV_STEP,
        CMD_MOD_DONE,
        CMD_EV_START,
        CMD_EV_K0,
        CMD_EV_TAKE,
        CMD_SCAN_INIT,
        CMD_EV_NEXT,
        CMD_EV_RIGHT,
        CMD_EV_LEFT,
        CMD_FRAC_FULL,
        CMD_FRAC_DIV,
        CMD_FRAC_TAKE,
        CMD_MUL,
        CMD_ACC,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic add_drop;
        logic n_zero;
        logic n_one;
        logic empty;
        logic adv_go;
        logic is_wrap;
        logic key_gt;
        logic j_one;
        logic tm_le_rd;
        logic tm_ge_rd;
        logic span_zero;
        logic diff_full;
        logic div_last;
        logic comp_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/kti_ram.sv
`default_nettype none

module kti_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/kti_datapath.sv
`default_nettype none

module kti_datapath #(
    parameter int KEYS_PER_TRACK = 16,
    parameter int TRACK_COUNT    = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kti_pkg::t_cmd       i_cmd,
    output kti_pkg::t_dp_stat        o_stat,
    input  wire logic [2:0]          i_operation,
    input  wire logic [1:0]          i_track,
    input  wire logic [31:0]         i_key_time,
    input  wire logic signed [31:0]  i_key_x,
    input  wire logic signed [31:0]  i_key_y,
    input  wire logic signed [31:0]  i_key_z,
    input  wire logic [15:0]         i_delta_time,
    input  wire logic [31:0]         i_new_duration,
    input  wire logic [1:0]          i_loop_mode,
    input  wire logic [15:0]         i_speed,
    input  wire logic                i_out_stall,
    output logic                     o_out_valid,
    output logic [31:0]              o_time_now,
    output logic                     o_is_playing,
    output logic signed [31:0]       o_value_x,
    output logic signed [31:0]       o_value_y,
    output logic signed [31:0]       o_value_z,
    output logic                     o_status
);

    import kti_pkg::*;

    localparam int DEPTH = TRACK_COUNT * KEYS_PER_TRACK;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(KEYS_PER_TRACK + 1);
    localparam int TW    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int SW    = AW + CW;

    // Latched transaction
    t_op                r_op;
    logic [1:0]         r_trk;
    logic [31:0]        r_ktime;
    logic [31:0]        r_kx;
    logic [31:0]        r_ky;
    logic [31:0]        r_kz;
    logic [15:0]        r_dt;
    logic [31:0]        r_ndur;

    // Playback and table state
    logic [CW-1:0]      r_count [TRACK_COUNT];
    logic [32:0]        r_phase;
    logic [31:0]        r_dur;
    logic               r_running;

    // Working registers
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      r_idx;
    logic [31:0]        r_tm;
    logic [KEY_W-1:0]   r_left;
    logic [KEY_W-1:0]   r_right;
    logic [31:0]        r_aprod;
    logic [32:0]        r_rem;
    logic [33:0]        r_dvd;
    logic [33:0]        r_div;
    logic [5:0]         r_cnt;
    logic [16:0]        r_frac;
    logic [1:0]         r_comp;
    logic signed [50:0] r_mprod;
    logic [31:0]        r_res_x;
    logic [31:0]        r_res_y;
    logic [31:0]        r_res_z;
    logic               r_status;

    // Output stage
    logic               r_o_valid;
    logic [31:0]        r_o_time;
    logic               r_o_play;
    logic [31:0]        r_o_x;
    logic [31:0]        r_o_y;
    logic [31:0]        r_o_z;
    logic               r_o_status;

    logic               trk_ok;
    logic [TW-1:0]      trk_i;
    logic [CW-1:0]      cur_n;
    logic [SW-1:0]      base_w;
    logic [CW-1:0]      rd_idx;
    logic               rd_en;
    logic               wr_en;
    logic [KEY_W-1:0]   wr_data;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [KEY_W-1:0]   rd_data;
    logic [31:0]        rd_t;
    logic [32:0]        two_d;
    logic [31:0]        ev_tm;
    logic [33:0]        adv_sum;
    logic               once_hit;
    logic               is_wrap;
    logic [33:0]        mod_div;
    logic [33:0]        div_t;
    logic               div_ge;
    logic [33:0]        div_sub;
    logic [31:0]        span;
    logic [31:0]        diff;
    logic [31:0]        a_c;
    logic [31:0]        b_c;
    logic signed [32:0] mul_d;
    logic signed [17:0] mul_f;
    logic [31:0]        acc_v;

    assign trk_ok = {1'b0, r_trk} < 3'(TRACK_COUNT);
    assign trk_i  = r_trk[TW-1:0];
    assign cur_n  = trk_ok ? r_count[trk_i] : '0;
    assign base_w = SW'(trk_i) * SW'(KEYS_PER_TRACK);
    assign rd_t   = rd_data[127:96];

    // Select the table entry to read for each command
    always_comb begin
        rd_en  = 1'b1;
        rd_idx = '0;
        case (i_cmd)
            CMD_INS_READ:  rd_idx = cur_n - CW'(1);
            CMD_INS_SHIFT: rd_idx = r_j - CW'(2);
            CMD_EV_START:  rd_idx = '0;
            CMD_EV_K0:     rd_idx = cur_n - CW'(1);
            CMD_SCAN_INIT: rd_idx = CW'(1);
            CMD_EV_NEXT:   rd_idx = r_idx + CW'(1);
            default:       rd_en  = 1'b0;
        endcase
    end

    assign wr_en   = (i_cmd == CMD_INS_SHIFT) || (i_cmd == CMD_INS_PUT);
    assign wr_data = (i_cmd == CMD_INS_SHIFT) ? rd_data : {r_ktime, r_kx, r_ky, r_kz};
    assign rd_addr = AW'(base_w + SW'(rd_idx));
    assign wr_addr = AW'(base_w + SW'(r_j));

    kti_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Evaluation time: mirror the second half of a ping-pong cycle
    assign two_d = {r_dur, 1'b0};
    always_comb begin
        if (i_loop_mode == MODE_PINGPONG && r_dur != '0 && r_phase > {1'b0, r_dur}) begin
            ev_tm = (r_phase >= two_d) ? '0 : 32'(two_d - r_phase);
        end else begin
            ev_tm = r_phase[32] ? '1 : r_phase[31:0];
        end
    end

    // Advance arithmetic
    assign adv_sum  = {1'b0, r_phase} + 34'(r_aprod[31:8]);
    assign once_hit = adv_sum >= {2'b0, r_dur};
    assign is_wrap  = (i_loop_mode == MODE_WRAP) || (i_loop_mode == MODE_PINGPONG);
    assign mod_div  = (i_loop_mode == MODE_WRAP) ? {2'b0, r_dur} : {1'b0, r_dur, 1'b0};

    // One restoring-division step, shared by the modulo and the fraction
    assign div_t   = {r_rem, r_dvd[33]};
    assign div_ge  = div_t >= r_div;
    assign div_sub = div_t - r_div;

    assign span = r_right[127:96] - r_left[127:96];
    assign diff = r_tm - r_left[127:96];

    // Pick one vector component for the shared multiplier
    always_comb begin
        case (r_comp)
            2'd0:    begin a_c = r_left[95:64]; b_c = r_right[95:64]; end
            2'd1:    begin a_c = r_left[63:32]; b_c = r_right[63:32]; end
            default: begin a_c = r_left[31:0];  b_c = r_right[31:0];  end
        endcase
    end

    assign mul_d = $signed({b_c[31], b_c}) - $signed({a_c[31], a_c});
    assign mul_f = $signed({1'b0, r_frac});
    assign acc_v = a_c + r_mprod[47:16];

    // Status toward the controller
    always_comb begin
        o_stat.op        = r_op;
        o_stat.add_drop  = !trk_ok || (cur_n == CW'(KEYS_PER_TRACK));
        o_stat.n_zero    = cur_n == '0;
        o_stat.n_one     = cur_n == CW'(1);
        o_stat.empty     = !trk_ok || (cur_n == '0);
        o_stat.adv_go    = r_running && (r_dur != '0);
        o_stat.is_wrap   = is_wrap;
        o_stat.key_gt    = rd_t > r_ktime;
        o_stat.j_one     = r_j == CW'(1);
        o_stat.tm_le_rd  = r_tm <= rd_t;
        o_stat.tm_ge_rd  = r_tm >= rd_t;
        o_stat.span_zero = span == '0;
        o_stat.diff_full = diff == span;
        o_stat.div_last  = r_cnt == 6'd1;
        o_stat.comp_last = r_comp == 2'd2;
        o_stat.out_free  = !r_o_valid || !i_out_stall;
    end

    // Execute controller commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '{default: '0};
            r_phase   <= '0;
            r_dur     <= '0;
            r_running <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_OUT) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_LATCH: begin
                    r_op     <= t_op'(i_operation);
                    r_trk    <= i_track;
                    r_ktime  <= i_key_time;
                    r_kx     <= i_key_x;
                    r_ky     <= i_key_y;
                    r_kz     <= i_key_z;
                    r_dt     <= i_delta_time;
                    r_ndur   <= i_new_duration;
                    r_status <= 1'b0;
                end
                CMD_CTRL: begin
                    case (r_op)
                        OP_PLAY:    r_running <= 1'b1;
                        OP_PAUSE:   r_running <= 1'b0;
                        OP_STOP: begin
                            r_running <= 1'b0;
                            r_phase   <= '0;
                        end
                        OP_SET_DUR: r_dur <= r_ndur;
                        default: ;
                    endcase
                end
                CMD_DROP:      r_status <= 1'b1;
                CMD_INS_READ:  r_j <= cur_n;
                CMD_INS_SHIFT: r_j <= r_j - CW'(1);
                CMD_INS_PUT: begin
                    r_count[trk_i] <= cur_n + CW'(1);
                    if (r_ktime > r_dur) begin
                        r_dur <= r_ktime;
                    end
                end
                CMD_ADV_MUL:   r_aprod <= 32'(r_dt) * 32'(i_speed);
                CMD_ADV_ADD: begin
                    if (is_wrap) begin
                        r_rem <= '0;
                        r_dvd <= adv_sum;
                        r_div <= mod_div;
                        r_cnt <= 6'(MOD_STEPS);
                    end else if (once_hit) begin
                        r_phase   <= {1'b0, r_dur};
                        r_running <= 1'b0;
                    end else begin
                        r_phase <= adv_sum[32:0];
                    end
                end
                CMD_DIV_STEP: begin
                    r_rem <= div_ge ? div_sub[32:0] : div_t[32:0];
                    r_dvd <= {r_dvd[32:0], div_ge};
                    r_cnt <= r_cnt - 6'd1;
                end
                CMD_MOD_DONE:  r_phase <= r_rem;
                CMD_EV_START: begin
                    r_tm    <= ev_tm;
                    r_res_x <= '0;
                    r_res_y <= '0;
                    r_res_z <= '0;
                end
                CMD_EV_K0: begin
                    r_left  <= rd_data;
                    r_res_x <= rd_data[95:64];
                    r_res_y <= rd_data[63:32];
                    r_res_z <= rd_data[31:0];
                end
                CMD_EV_TAKE: begin
                    r_res_x <= rd_data[95:64];
                    r_res_y <= rd_data[63:32];
                    r_res_z <= rd_data[31:0];
                end
                CMD_SCAN_INIT: r_idx <= CW'(1);
                CMD_EV_NEXT: begin
                    r_left <= rd_data;
                    r_idx  <= r_idx + CW'(1);
                end
                CMD_EV_RIGHT:  r_right <= rd_data;
                CMD_EV_LEFT: begin
                    r_res_x <= r_left[95:64];
                    r_res_y <= r_left[63:32];
                    r_res_z <= r_left[31:0];
                end
                CMD_FRAC_FULL: begin
                    r_frac <= 17'h10000;
                    r_comp <= '0;
                end
                CMD_FRAC_DIV: begin
                    r_rem <= {1'b0, diff};
                    r_dvd <= '0;
                    r_div <= {2'b0, span};
                    r_cnt <= 6'(FRAC_STEPS);
                end
                CMD_FRAC_TAKE: begin
                    r_frac <= {1'b0, r_dvd[15:0]};
                    r_comp <= '0;
                end
                CMD_MUL:       r_mprod <= mul_d * mul_f;
                CMD_ACC: begin
                    case (r_comp)
                        2'd0:    r_res_x <= acc_v;
                        2'd1:    r_res_y <= acc_v;
                        default: r_res_z <= acc_v;
                    endcase
                    r_comp <= r_comp + 2'd1;
                end
                CMD_OUT: begin
                    r_o_time   <= r_tm;
                    r_o_play   <= r_running;
                    r_o_x      <= r_res_x;
                    r_o_y      <= r_res_y;
                    r_o_z      <= r_res_z;
                    r_o_status <= r_status;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_time_now   = r_o_time;
    assign o_is_playing = r_o_play;
    assign o_value_x    = r_o_x;
    assign o_value_y    = r_o_y;
    assign o_value_z    = r_o_z;
    assign o_status     = r_o_status;

endmodule

`default_nettype wire

### rtl/core/kti_ctrl.sv
`default_nettype none

module kti_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire kti_pkg::t_dp_stat i_stat,
    output kti_pkg::t_cmd          o_cmd,
    output logic                   o_in_ready
);

    import kti_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_ADD_KEY: begin
                        if (i_stat.add_drop)    n_state = S_EV_START;
                        else if (i_stat.n_zero) n_state = S_INS_PUT;
                        else                    n_state = S_INS_WT;
                    end
                    OP_ADVANCE: n_state = i_stat.adv_go ? S_ADV_ADD : S_EV_START;
                    default:    n_state = S_EV_START;
                endcase
            end
            S_INS_WT: begin
                if (!i_stat.key_gt)    n_state = S_EV_START;
                else if (i_stat.j_one) n_state = S_INS_PUT;
            end
            S_INS_PUT:  n_state = S_EV_START;
            S_ADV_ADD:  n_state = i_stat.is_wrap ? S_MOD_DIV : S_EV_START;
            S_MOD_DIV: begin
                if (i_stat.div_last) n_state = S_MOD_DONE;
            end
            S_MOD_DONE: n_state = S_EV_START;
            S_EV_START: n_state = i_stat.empty ? S_DONE : S_EV_K0;
            S_EV_K0:    n_state = (i_stat.n_one || i_stat.tm_le_rd) ? S_DONE : S_EV_KL;
            S_EV_KL:    n_state = i_stat.tm_ge_rd ? S_DONE : S_EV_SCAN;
            S_EV_SCAN: begin
                if (i_stat.tm_le_rd) n_state = S_FRAC;
            end
            S_FRAC: begin
                if (i_stat.span_zero)      n_state = S_DONE;
                else if (i_stat.diff_full) n_state = S_MUL;
                else                       n_state = S_FRAC_DIV;
            end
            S_FRAC_DIV: begin
                if (i_stat.div_last) n_state = S_FRAC_TAKE;
            end
            S_FRAC_TAKE: n_state = S_MUL;
            S_MUL:       n_state = S_ACC;
            S_ACC:       n_state = i_stat.comp_last ? S_DONE : S_MUL;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_LATCH;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_ADD_KEY: o_cmd = i_stat.add_drop ? CMD_DROP : CMD_INS_READ;
                    OP_ADVANCE: o_cmd = i_stat.adv_go ? CMD_ADV_MUL : CMD_NONE;
                    default:    o_cmd = CMD_CTRL;
                endcase
            end
            S_INS_WT:    o_cmd = i_stat.key_gt ? CMD_INS_SHIFT : CMD_INS_PUT;
            S_INS_PUT:   o_cmd = CMD_INS_PUT;
            S_ADV_ADD:   o_cmd = CMD_ADV_ADD;
            S_MOD_DIV:   o_cmd = CMD_DIV_STEP;
            S_MOD_DONE:  o_cmd = CMD_MOD_DONE;
            S_EV_START:  o_cmd = CMD_EV_START;
            S_EV_K0:     o_cmd = CMD_EV_K0;
            S_EV_KL:     o_cmd = i_stat.tm_ge_rd ? CMD_EV_TAKE : CMD_SCAN_INIT;
            S_EV_SCAN:   o_cmd = i_stat.tm_le_rd ? CMD_EV_RIGHT : CMD_EV_NEXT;
            S_FRAC: begin
                if (i_stat.span_zero)      o_cmd = CMD_EV_LEFT;
                else if (i_stat.diff_full) o_cmd = CMD_FRAC_FULL;
                else                       o_cmd = CMD_FRAC_DIV;
            end
            S_FRAC_DIV:  o_cmd = CMD_DIV_STEP;
            S_FRAC_TAKE: o_cmd = CMD_FRAC_TAKE;
            S_MUL:       o_cmd = CMD_MUL;
            S_ACC:       o_cmd = CMD_ACC;
            S_DONE:      o_cmd = i_stat.out_free ? CMD_OUT : CMD_NONE;
            default:     o_cmd = CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/keyframe_timeline_interpolator.sv
`default_nettype none

// Channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// input    | i_valid / o_stall  | i_operation i_track i_key_time i_key_x/y/z
//          |                    | i_delta_time i_new_duration
// output   | o_valid / i_stall  | o_time_now o_is_playing o_value_x/y/z o_status
// config   | APB psel..pready   | loop_mode at 0x0, speed at 0x4
//
// One transaction at a time through a controller and a shared datapath; an item
// is accepted, decoded and finished, with keyframes moved and the new key written
// on insert, the scaled step added on advance (with the 34-step modulo in wrap and
// ping-pong), and for interpolation the end keys read, a scan over the keys, the
// fraction division and a multiply and accumulate per component.
// Synchronous active-low reset clears counts, phase, duration, playback and output valid.
// A finished result waits in the output register while the next item is taken.

module keyframe_timeline_interpolator #(
    parameter int KEYS_PER_TRACK = 16,
    parameter int TRACK_COUNT    = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_operation,
    input  wire logic [1:0]         i_track,
    input  wire logic [31:0]        i_key_time,
    input  wire logic signed [31:0] i_key_x,
    input  wire logic signed [31:0] i_key_y,
    input  wire logic signed [31:0] i_key_z,
    input  wire logic [15:0]        i_delta_time,
    input  wire logic [31:0]        i_new_duration,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [31:0]             o_time_now,
    output logic                    o_is_playing,
    output logic signed [31:0]      o_value_x,
    output logic signed [31:0]      o_value_y,
    output logic signed [31:0]      o_value_z,
    output logic                    o_status,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    import kti_pkg::*;

    logic [1:0]  r_loop_mode;
    logic [15:0] r_speed;
    logic        cfg_wr;
    logic        in_ready;
    t_cmd        cmd;
    t_dp_stat    stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode <= MODE_ONCE;
            r_speed     <= SPEED_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LOOP_MODE: r_loop_mode <= pwdata[1:0];
                REG_SPEED:     r_speed     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LOOP_MODE: prdata = {30'b0, r_loop_mode};
            REG_SPEED:     prdata = {16'b0, r_speed};
            default:       prdata = '0;
        endcase
    end

    assign o_stall = !in_ready;

    kti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    kti_datapath #(
        .KEYS_PER_TRACK (KEYS_PER_TRACK),
        .TRACK_COUNT    (TRACK_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_track        (i_track),
        .i_key_time     (i_key_time),
        .i_key_x        (i_key_x),
        .i_key_y        (i_key_y),
        .i_key_z        (i_key_z),
        .i_delta_time   (i_delta_time),
        .i_new_duration (i_new_duration),
        .i_loop_mode    (r_loop_mode),
        .i_speed        (r_speed),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_time_now     (o_time_now),
        .o_is_playing   (o_is_playing),
        .o_value_x      (o_value_x),
        .o_value_y      (o_value_y),
        .o_value_z      (o_value_z),
        .o_status       (o_status)
    );

    // An accepted transaction keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after a transaction");

    // A new result only appears while a transaction is in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no transaction in progress");

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import kti_pkg::*;

    localparam int NKEY = 16;
    localparam int NTRK = 4;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  op;
        logic [1:0]  trk;
        logic [31:0] ktime;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [15:0] dt;
        logic [31:0] ndur;
    } t_cmd_item;

    typedef struct {
        logic [31:0] tnow;
        logic        playing;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        stat;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_operation = '0;
    logic [1:0] i_track = '0;
    logic [31:0] i_key_time = '0;
    logic signed [31:0] i_key_x = '0;
    logic signed [31:0] i_key_y = '0;
    logic signed [31:0] i_key_z = '0;
    logic [15:0] i_delta_time = '0;
    logic [31:0] i_new_duration = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [31:0] o_time_now;
    logic o_is_playing;
    logic signed [31:0] o_value_x;
    logic signed [31:0] o_value_y;
    logic signed [31:0] o_value_z;
    logic o_status;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    keyframe_timeline_interpolator DUT (.*);

    always #10 i_clk = ~i_clk;

    // Timeline shadow state
    logic [31:0] key_t [NTRK][NKEY];
    logic [31:0] key_v [NTRK][NKEY][3];
    int unsigned key_n [NTRK];
    logic [32:0] play_phase;
    logic [31:0] play_dur;
    logic        play_run;
    logic [1:0]  mode_q;
    logic [15:0] speed_q;

    t_cmd_item pending_q[$];
    t_report   report_q[$];
    int mismatch_cnt = 0;
    int idle_cycles = 0;

    function automatic logic [31:0] time_at();
        logic [33:0] p;
        logic [33:0] d;
        p = 34'(play_phase);
        d = 34'(play_dur);
        if (mode_q == MODE_PINGPONG && d != 0 && p > d) begin
            if (p >= 2 * d) return 32'd0;
            return 32'(2 * d - p);
        end
        return p > 34'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(p);
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint frac);
        longint prod;
        longint q;
        prod = (longint'($signed(b)) - longint'($signed(a))) * frac;
        if (prod >= 0) q = prod >>> 16;
        else q = -((-prod + 65535) >>> 16);
        return 32'(longint'($signed(a)) + q);
    endfunction

    // Compute the report for one transaction and update the shadow state
    function automatic t_report timeline_step(t_cmd_item c);
        t_report r;
        int unsigned n;
        int unsigned pos;
        logic [31:0] tm;
        logic [63:0] span;
        logic [33:0] adv_p;
        longint frac;
        bit hit;
        r = '{default: '0};
        case (c.op)
            OP_ADD_KEY: begin
                n = key_n[c.trk];
                if (n >= NKEY) begin
                    r.stat = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < n && key_t[c.trk][pos] <= c.ktime) pos++;
                    for (int j = n; j > pos; j--) begin
                        key_t[c.trk][j] = key_t[c.trk][j-1];
                        key_v[c.trk][j] = key_v[c.trk][j-1];
                    end
                    key_t[c.trk][pos] = c.ktime;
                    key_v[c.trk][pos][0] = c.kx;
                    key_v[c.trk][pos][1] = c.ky;
                    key_v[c.trk][pos][2] = c.kz;
                    key_n[c.trk] = n + 1;
                    if (c.ktime > play_dur) play_dur = c.ktime;
                end
            end
            OP_ADVANCE: begin
                if (play_run && play_dur != 0) begin
                    // Keep the sum wide: a ping-pong phase near twice the duration
                    // plus the step can pass 33 bits
                    adv_p = 34'(play_phase) + ((34'(c.dt) * 34'(speed_q)) >> 8);
                    if (mode_q == MODE_WRAP) begin
                        play_phase = 33'(adv_p % 34'(play_dur));
                    end else if (mode_q == MODE_PINGPONG) begin
                        play_phase = 33'(adv_p % (34'(play_dur) * 34'd2));
                    end else if (adv_p >= 34'(play_dur)) begin
                        play_phase = 33'(play_dur);
                        play_run = 1'b0;
                    end else begin
                        play_phase = 33'(adv_p);
                    end
                end
            end
            OP_PLAY:  play_run = 1'b1;
            OP_PAUSE: play_run = 1'b0;
            OP_STOP: begin
                play_run = 1'b0;
                play_phase = '0;
            end
            OP_SET_DUR: play_dur = c.ndur;
            default: ;
        endcase
        tm = time_at();
        r.tnow = tm;
        r.playing = play_run;
        n = key_n[c.trk];
        if (n != 0) begin
            if (n == 1 || tm <= key_t[c.trk][0]) begin
                {r.vx, r.vy, r.vz} = {key_v[c.trk][0][0], key_v[c.trk][0][1],
                                      key_v[c.trk][0][2]};
            end else if (tm >= key_t[c.trk][n-1]) begin
                {r.vx, r.vy, r.vz} = {key_v[c.trk][n-1][0], key_v[c.trk][n-1][1],
                                      key_v[c.trk][n-1][2]};
            end else begin
                hit = 1'b0;
                for (int i = 0; i + 1 < n && !hit; i++) begin
                    if (tm >= key_t[c.trk][i] && tm <= key_t[c.trk][i+1]) begin
                        hit = 1'b1;
                        span = key_t[c.trk][i+1] - key_t[c.trk][i];
                        if (span == 0) begin
                            {r.vx, r.vy, r.vz} = {key_v[c.trk][i][0],
                                key_v[c.trk][i][1], key_v[c.trk][i][2]};
                        end else begin
                            frac = longint'(((64'(tm) - key_t[c.trk][i]) << 16) / span);
                            r.vx = blend(key_v[c.trk][i][0], key_v[c.trk][i+1][0], frac);
                            r.vy = blend(key_v[c.trk][i][1], key_v[c.trk][i+1][1], frac);
                            r.vz = blend(key_v[c.trk][i][2], key_v[c.trk][i+1][2], frac);
                        end
                    end
                end
                if (!hit) {r.vx, r.vy, r.vz} = {key_v[c.trk][n-1][0],
                    key_v[c.trk][n-1][1], key_v[c.trk][n-1][2]};
            end
        end
        return r;
    endfunction

    // Driver: present pending transactions with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                report_q.push_back(timeline_step(pending_q.pop_front()));
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if ((!i_valid || !o_stall) && pending_q.size() > 0 &&
                         !(i_valid && !o_stall && pending_q.size() == 0)) begin
                i_valid        <= 1'b1;
                i_operation    <= pending_q[0].op;
                i_track        <= pending_q[0].trk;
                i_key_time     <= pending_q[0].ktime;
                i_key_x        <= pending_q[0].kx;
                i_key_y        <= pending_q[0].ky;
                i_key_z        <= pending_q[0].kz;
                i_delta_time   <= pending_q[0].dt;
                i_new_duration <= pending_q[0].ndur;
            end else if (!i_valid || !o_stall) begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted report with the oldest prediction
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (o_valid && !i_stall) begin
                if (report_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected report at %0t", $realtime);
                end else begin
                    e = report_q.pop_front();
                    if (e.tnow !== o_time_now || e.playing !== o_is_playing ||
                        e.vx !== o_value_x || e.vy !== o_value_y ||
                        e.vz !== o_value_z || e.stat !== o_status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("mismatch: exp t=%h p=%b v=%h %h %h s=%b, ",
                                e.tnow, e.playing, e.vx, e.vy, e.vz, e.stat);
                            $display("got t=%h p=%b v=%h %h %h s=%b", o_time_now,
                                o_is_playing, o_value_x, o_value_y, o_value_z, o_status);
                        end
                    end
                end
                hold_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("keyframe_timeline_interpolator verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) mode_q = data[1:0];
        else speed_q = data[15:0];
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || report_q.size() > 0 || i_valid) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_cmd_item mk(logic [2:0] op, logic [1:0] trk, logic [31:0] kt,
                                     logic [31:0] v, logic [15:0] dt, logic [31:0] nd);
        t_cmd_item c;
        c = '{op, trk, kt, v, ~v, v ^ 32'h8000_0000, dt, nd};
        return c;
    endfunction

    // Random sequence: mostly advances and key adds, mixed with play, pause, stop, set-duration and unused codes
    task automatic random_phase(int count);
        t_cmd_item c;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            c.trk = 2'($urandom_range(0, 3));
            c.ktime = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
            c.kx = $urandom; c.ky = $urandom; c.kz = $urandom;
            c.dt = 16'($urandom); c.ndur = ($urandom_range(0, 9) == 0) ? $urandom
                                    : $urandom_range(0, 32'h0008_0000);
            if (r < 25) c.op = OP_ADD_KEY;
            else if (r < 70) c.op = OP_ADVANCE;
            else if (r < 80) c.op = OP_PLAY;
            else if (r < 85) c.op = OP_PAUSE;
            else if (r < 90) c.op = OP_STOP;
            else if (r < 95) c.op = OP_SET_DUR;
            else c.op = 3'($urandom_range(6, 7));
            pending_q.push_back(c);
        end
    endtask

    initial begin
        for (int t = 0; t < NTRK; t++) key_n[t] = 0;
        play_phase = '0; play_dur = '0; play_run = 1'b0;
        mode_q = MODE_ONCE; speed_q = SPEED_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty track, one key, extremes, all operations, full track
        pending_q.push_back(mk(OP_ADVANCE, 0, 0, 0, 16'hFFFF, 0));
        pending_q.push_back(mk(OP_ADD_KEY, 0, 32'h0001_0000, 32'h7FFF_FFFF, 0, 0));
        pending_q.push_back(mk(OP_ADD_KEY, 0, 32'h0001_0000, 32'h8000_0000, 0, 0));
        pending_q.push_back(mk(OP_ADD_KEY, 0, 32'h0000_0000, 32'h0000_0000, 0, 0));
        pending_q.push_back(mk(OP_ADD_KEY, 0, 32'h0003_0000, 32'hFFFF_FFFF, 0, 0));
        pending_q.push_back(mk(OP_PLAY, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_ADVANCE, 0, 0, 0, 16'h8000, 0));
        pending_q.push_back(mk(OP_ADVANCE, 0, 0, 0, 16'hFFFF, 0));
        pending_q.push_back(mk(OP_PAUSE, 0, 0, 0, 16'hFFFF, 0));
        pending_q.push_back(mk(OP_ADVANCE, 0, 0, 0, 16'hFFFF, 0));
        pending_q.push_back(mk(OP_PLAY, 0, 0, 0, 0, 0));
        for (int k = 0; k < 6; k++) pending_q.push_back(mk(OP_ADVANCE, 0, 0, 0, 16'hFFFF, 0));
        pending_q.push_back(mk(OP_STOP, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_SET_DUR, 0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_q.push_back(mk(OP_SET_DUR, 0, 0, 0, 0, 32'h0002_0000));
        pending_q.push_back(mk(3'd6, 3, 0, 0, 0, 0));
        pending_q.push_back(mk(3'd7, 3, 32'hFFFF_FFFF, 32'h1234_5678, 0, 0));
        for (int k = 0; k < 17; k++)
            pending_q.push_back(mk(OP_ADD_KEY, 1, k * 32'h0000_4000, $urandom, 0, 0));
        wait_drained();

        // Sweep loop modes and speeds, including extremes
        write_reg(3'd0, MODE_WRAP);  write_reg(3'd4, 32'hFFFF);
        pending_q.push_back(mk(OP_PLAY, 0, 0, 0, 0, 0));
        random_phase(80); wait_drained();
        write_reg(3'd0, MODE_PINGPONG); write_reg(3'd4, 32'd256);
        pending_q.push_back(mk(OP_STOP, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_PLAY, 0, 0, 0, 0, 0));
        random_phase(90); wait_drained();
        write_reg(3'd4, 32'd0);
        random_phase(40); wait_drained();
        write_reg(3'd0, 32'd3); write_reg(3'd4, 32'h0800);
        random_phase(80); wait_drained();
        write_reg(3'd0, MODE_ONCE); write_reg(3'd4, 32'd77);
        random_phase(80); wait_drained();

        if (mismatch_cnt == 0) begin
            $display("keyframe_timeline_interpolator verification clean");
        end else begin
            $display("keyframe_timeline_interpolator verification failed");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/kti_pkg.sv
rtl/core/kti_ram.sv
rtl/core/kti_datapath.sv
rtl/core/kti_ctrl.sv
rtl/core/keyframe_timeline_interpolator.sv
tb/tb.sv
